// ===== rtl/core/masked_raster_statistics_defines.svh =====
// Assertion macros shared by the masked raster statistics modules.
`ifndef MASKED_RASTER_STATISTICS_DEFINES_SVH
`define MASKED_RASTER_STATISTICS_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Check that a condition holds in the cycle after its trigger.
`define MRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/mrs_pkg.sv =====
// Shared types and constants of the masked raster statistics block.
package mrs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_SAMPLES_DEF = 1048576;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int RES_W           = 32;
    localparam int CFG_W           = 16;
    localparam logic [CFG_W-1:0] NODATA_RESET = 16'h8000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_MA,
        S_MA,
        S_LD_MB,
        S_MB,
        S_LD_SQ,
        S_SQ,
        S_LD_DM,
        S_DM,
        S_LD_DS,
        S_DS,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_MA,
        OP_LOAD_MB,
        OP_MUL_STEP,
        OP_LOAD_SQ,
        OP_SQRT_STEP,
        OP_LOAD_DM,
        OP_LOAD_DS,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accum;
    } ctl_cmd_t;

    typedef struct packed {
        logic step_done;
    } dp_status_t;

endpackage

// ===== rtl/core/mrs_ctrl.sv =====
// Frame sequencer: accumulate, then multiply, square root and divide phases.
`include "masked_raster_statistics_defines.svh"

module mrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last,
    input  mrs_pkg::dp_status_t status,
    output mrs_pkg::ctl_cmd_t   cmd,
    output logic                busy
);

    mrs_pkg::state_t state_reg;
    mrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mrs_pkg::OP_NONE;
        cmd.accum  = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            mrs_pkg::S_IDLE:
            begin
                busy      = 1'b0;
                cmd.accum = start;
                if (start && last)
                begin
                    state_next = mrs_pkg::S_LD_MA;
                end
            end
            mrs_pkg::S_LD_MA:
            begin
                cmd.op     = mrs_pkg::OP_LOAD_MA;
                state_next = mrs_pkg::S_MA;
            end
            mrs_pkg::S_MA:
            begin
                cmd.op = mrs_pkg::OP_MUL_STEP;
                if (status.step_done)
                begin
                    state_next = mrs_pkg::S_LD_MB;
                end
            end
            mrs_pkg::S_LD_MB:
            begin
                cmd.op     = mrs_pkg::OP_LOAD_MB;
                state_next = mrs_pkg::S_MB;
            end
            mrs_pkg::S_MB:
            begin
                cmd.op = mrs_pkg::OP_MUL_STEP;
                if (status.step_done)
                begin
                    state_next = mrs_pkg::S_LD_SQ;
                end
            end
            mrs_pkg::S_LD_SQ:
            begin
                cmd.op     = mrs_pkg::OP_LOAD_SQ;
                state_next = mrs_pkg::S_SQ;
            end
            mrs_pkg::S_SQ:
            begin
                cmd.op = mrs_pkg::OP_SQRT_STEP;
                if (status.step_done)
                begin
                    state_next = mrs_pkg::S_LD_DM;
                end
            end
            mrs_pkg::S_LD_DM:
            begin
                cmd.op     = mrs_pkg::OP_LOAD_DM;
                state_next = mrs_pkg::S_DM;
            end
            mrs_pkg::S_DM:
            begin
                cmd.op = mrs_pkg::OP_DIV_STEP;
                if (status.step_done)
                begin
                    state_next = mrs_pkg::S_LD_DS;
                end
            end
            mrs_pkg::S_LD_DS:
            begin
                cmd.op     = mrs_pkg::OP_LOAD_DS;
                state_next = mrs_pkg::S_DS;
            end
            mrs_pkg::S_DS:
            begin
                cmd.op = mrs_pkg::OP_DIV_STEP;
                if (status.step_done)
                begin
                    state_next = mrs_pkg::S_EMIT;
                end
            end
            mrs_pkg::S_EMIT:
            begin
                cmd.op     = mrs_pkg::OP_EMIT;
                state_next = mrs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mrs_pkg::S_IDLE;
            end
        endcase
    end

    `MRS_ASSERT_NEXT(a_busy_after_last, cmd.accum && last, busy)
    `MRS_ASSERT_NEXT(a_emit_frees, state_reg == mrs_pkg::S_EMIT, !busy)

endmodule

// ===== rtl/core/mrs_datapath.sv =====
// Accumulators, shift-add multiplier, square root and divider of the statistics block.
`include "masked_raster_statistics_defines.svh"

module mrs_datapath #(
    parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = mrs_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = mrs_pkg::FRAC_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mrs_pkg::ctl_cmd_t                  cmd,
    output mrs_pkg::dp_status_t                status,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               cfg_valid,
    input  logic signed [mrs_pkg::CFG_W-1:0]   cfg_data,
    output logic [CNT_W-1:0]                   valid_count,
    output logic signed [SAMPLE_BITS-1:0]      min_value,
    output logic signed [SAMPLE_BITS-1:0]      max_value,
    output logic signed [mrs_pkg::RES_W-1:0]   mean_fixed,
    output logic [mrs_pkg::RES_W-1:0]          std_fixed,
    output logic                               none_valid,
    output logic                               overflow,
    output logic                               done
);

    localparam int RES_W  = mrs_pkg::RES_W;
    localparam int CFG_W  = mrs_pkg::CFG_W;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int PA_W   = CNT_W + SQ_W;
    localparam int PB_W   = 2 * SUM_W;
    localparam int V_W    = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int RAD_W  = V_W + 2 * FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int RP_W   = 2 * ROOT_W;
    localparam int SR_W   = ROOT_W + 2;
    localparam int DV_A   = SUM_W + FRAC_BITS;
    localparam int DV_W   = (DV_A > ROOT_W) ? DV_A : ROOT_W;
    localparam int MQ_W   = (DV_W + 1 > RES_W) ? DV_W + 1 : RES_W;
    localparam int NDW    = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int MAXSTP = (DV_W > SUM_W) ? DV_W : SUM_W;
    localparam int STEP_W = $clog2(MAXSTP + 1);

    // frame state
    logic [CFG_W-1:0]              nodata_reg, nodata_next;
    logic [CNT_W-1:0]              tally_reg, tally_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]               sq_reg, sq_next;
    logic                          ovf_reg, ovf_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          done_reg, done_next;

    // finishing datapath
    logic [V_W-1:0]    acc_reg, acc_next;
    logic [V_W-1:0]    mcand_reg, mcand_next;
    logic [SUM_W-1:0]  mplier_reg, mplier_next;
    logic [V_W-1:0]    prod_reg, prod_next;
    logic [RP_W-1:0]   rad_reg, rad_next;
    logic [SR_W-1:0]   srem_reg, srem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DV_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]  drem_reg, drem_next;
    logic [RES_W-1:0]  mean_reg, mean_next;

    // result word
    logic [CNT_W-1:0]              cnt_o_reg, cnt_o_next;
    logic signed [SAMPLE_BITS-1:0] min_o_reg, min_o_next;
    logic signed [SAMPLE_BITS-1:0] max_o_reg, max_o_next;
    logic [RES_W-1:0]              mean_o_reg, mean_o_next;
    logic [RES_W-1:0]              std_o_reg, std_o_next;
    logic                          none_o_reg, none_o_next;
    logic                          ovf_o_reg, ovf_o_next;

    logic [NDW-1:0]                nd_wide;
    logic signed [SAMPLE_BITS-1:0] nd_s;
    logic signed [2*SAMPLE_BITS-1:0] sqr;
    logic                          is_valid;
    logic                          sum_neg;
    logic [SUM_W-1:0]              mag;
    logic signed [RES_W-1:0]       fill;
    logic [V_W-1:0]                diff;
    logic [SR_W+1:0]               sq_sh;
    logic [SR_W+1:0]               sq_trial;
    logic [CNT_W:0]                dv_trial;
    logic                          dv_ge;
    logic [MQ_W-1:0]               q_ext;
    logic [MQ_W-1:0]               q_adj;
    logic [MQ_W-1:0]               q_neg;
    logic [MQ_W-1:0]               root_q;

    always_comb
    begin
        nd_wide  = NDW'(nodata_reg);
        nd_s     = nd_wide[SAMPLE_BITS-1:0];
        is_valid = (sample != nd_s);
        sqr      = sample * sample;
        sum_neg  = sum_reg[SUM_W-1];
        mag      = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        fill     = RES_W'(nd_s) <<< FRAC_BITS;
        diff     = (prod_reg >= acc_reg) ? (prod_reg - acc_reg) : '0;
        sq_sh    = {srem_reg, rad_reg[RP_W-1 -: 2]};
        sq_trial = {SR_W'(root_reg), 2'b01};
        dv_trial = {drem_reg, dvd_reg[DV_W-1]};
        dv_ge    = (dv_trial >= {1'b0, tally_reg});
        q_ext    = MQ_W'(dvd_reg);
        q_adj    = q_ext + MQ_W'(drem_reg != '0);
        q_neg    = -q_adj;
        root_q   = MQ_W'(dvd_reg);
    end

    always_comb
    begin
        nodata_next = nodata_reg;
        tally_next  = tally_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        ovf_next    = ovf_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        rad_next    = rad_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        dvd_next    = dvd_reg;
        drem_next   = drem_reg;
        mean_next   = mean_reg;
        cnt_o_next  = cnt_o_reg;
        min_o_next  = min_o_reg;
        max_o_next  = max_o_reg;
        mean_o_next = mean_o_reg;
        std_o_next  = std_o_reg;
        none_o_next = none_o_reg;
        ovf_o_next  = ovf_o_reg;

        if (cfg_valid)
        begin
            nodata_next = CFG_W'(cfg_data);
        end

        if (cmd.accum && is_valid)
        begin
            if (tally_reg == CNT_W'(MAX_SAMPLES))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (tally_reg == '0 || sample < min_reg)
                begin
                    min_next = sample;
                end
                if (tally_reg == '0 || sample > max_reg)
                begin
                    max_next = sample;
                end
                sum_next   = sum_reg + SUM_W'(sample);
                sq_next    = sq_reg + SQ_W'(sqr[2*SAMPLE_BITS-2:0]);
                tally_next = tally_reg + 1'b1;
            end
        end

        unique case (cmd.op)
            mrs_pkg::OP_NONE:
            begin
            end
            mrs_pkg::OP_LOAD_MA:
            begin
                acc_next    = '0;
                mcand_next  = V_W'(sq_reg);
                mplier_next = SUM_W'(tally_reg);
                step_next   = STEP_W'(CNT_W);
            end
            mrs_pkg::OP_LOAD_MB:
            begin
                prod_next   = acc_reg;
                acc_next    = '0;
                mcand_next  = V_W'(mag);
                mplier_next = mag;
                step_next   = STEP_W'(SUM_W);
            end
            mrs_pkg::OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
            end
            mrs_pkg::OP_LOAD_SQ:
            begin
                // scale N^2 times the variance so the root carries the fraction bits
                rad_next  = RP_W'(diff) << (2 * FRAC_BITS);
                srem_next = '0;
                root_next = '0;
                step_next = STEP_W'(ROOT_W);
            end
            mrs_pkg::OP_SQRT_STEP:
            begin
                if (sq_sh >= sq_trial)
                begin
                    srem_next = SR_W'(sq_sh - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = SR_W'(sq_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = rad_reg << 2;
                step_next = step_reg - 1'b1;
            end
            mrs_pkg::OP_LOAD_DM:
            begin
                dvd_next  = DV_W'(mag) << FRAC_BITS;
                drem_next = '0;
                step_next = STEP_W'(DV_W);
            end
            mrs_pkg::OP_LOAD_DS:
            begin
                // round a negative mean towards minus infinity
                mean_next = sum_neg ? RES_W'(q_neg) : RES_W'(q_ext);
                dvd_next  = DV_W'(root_reg);
                drem_next = '0;
                step_next = STEP_W'(DV_W);
            end
            mrs_pkg::OP_DIV_STEP:
            begin
                drem_next = dv_ge ? CNT_W'(dv_trial - {1'b0, tally_reg})
                                  : CNT_W'(dv_trial);
                dvd_next  = {dvd_reg[DV_W-2:0], dv_ge};
                step_next = step_reg - 1'b1;
            end
            mrs_pkg::OP_EMIT:
            begin
                done_next   = 1'b1;
                cnt_o_next  = tally_reg;
                min_o_next  = min_reg;
                max_o_next  = max_reg;
                none_o_next = (tally_reg == '0);
                ovf_o_next  = ovf_reg;
                mean_o_next = (tally_reg == '0) ? fill : mean_reg;
                std_o_next  = (tally_reg == '0) ? fill : RES_W'(root_q);
                // drop the frame state for the next raster
                tally_next  = '0;
                min_next    = '0;
                max_next    = '0;
                sum_next    = '0;
                sq_next     = '0;
                ovf_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_reg <= mrs_pkg::NODATA_RESET;
            tally_reg  <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            ovf_reg    <= 1'b0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            nodata_reg <= nodata_next;
            tally_reg  <= tally_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            ovf_reg    <= ovf_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        dvd_reg    <= dvd_next;
        drem_reg   <= drem_next;
        mean_reg   <= mean_next;
        cnt_o_reg  <= cnt_o_next;
        min_o_reg  <= min_o_next;
        max_o_reg  <= max_o_next;
        mean_o_reg <= mean_o_next;
        std_o_reg  <= std_o_next;
        none_o_reg <= none_o_next;
        ovf_o_reg  <= ovf_o_next;
    end

    assign status.step_done = (step_reg == STEP_W'(1));
    assign valid_count      = cnt_o_reg;
    assign min_value        = min_o_reg;
    assign max_value        = max_o_reg;
    assign mean_fixed       = mean_o_reg;
    assign std_fixed        = std_o_reg;
    assign none_valid       = none_o_reg;
    assign overflow         = ovf_o_reg;
    assign done             = done_reg;

    `MRS_ASSERT_NOW(a_frame_cleared, done_reg, tally_reg == '0 && sum_reg == '0)
    `MRS_ASSERT_NOW(a_ovf_saturated, ovf_reg, tally_reg == CNT_W'(MAX_SAMPLES))

endmodule

// ===== rtl/core/masked_raster_statistics.sv =====
// Finishing: after the last sample the result strobe follows two multiply phases, a square
// root phase and two divide phases, run in that order by the bit-serial multiplier, square
// root and divider that share one sequencer.
// Throughput: one sample per cycle within a frame; busy stays high while a frame finishes.
// Reset: rst_n clears the frame state and sets the no-data value to -32768.
// Results cannot be held off; done is high for one cycle with each, and the values hold until the next result.
module masked_raster_statistics #(
    parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = mrs_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = mrs_pkg::FRAC_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [mrs_pkg::CFG_W-1:0]  cfg_data,
    output logic                              done,
    output logic [CNT_W-1:0]                  valid_count,
    output logic signed [SAMPLE_BITS-1:0]     min_value,
    output logic signed [SAMPLE_BITS-1:0]     max_value,
    output logic signed [mrs_pkg::RES_W-1:0]  mean_fixed,
    output logic [mrs_pkg::RES_W-1:0]         std_fixed,
    output logic                              none_valid,
    output logic                              overflow
);

    mrs_pkg::ctl_cmd_t   cmd;
    mrs_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mrs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (sample),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .valid_count (valid_count),
        .min_value   (min_value),
        .max_value   (max_value),
        .mean_fixed  (mean_fixed),
        .std_fixed   (std_fixed),
        .none_valid  (none_valid),
        .overflow    (overflow),
        .done        (done)
    );

endmodule
